[rtl/core/bcp_pkg.sv]
// Shared types and helpers for the barometric sensor compensation pipeline.
// No dependencies.
package bcp_pkg;

   localparam int CsrIndexWidth = 2;
   localparam logic [1:0] CsrCalA = 2'd0;
   localparam logic [1:0] CsrCalB = 2'd1;
   localparam logic [1:0] CsrCalC = 2'd2;
   localparam logic [1:0] CsrOss  = 2'd3;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [23:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temperature_tenths;
      logic [19:0]        pressure_pa;
      logic               divide_fault;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] ac1;
      logic signed [15:0] ac2;
      logic signed [15:0] ac3;
      logic [15:0]        ac4;
      logic [15:0]        ac5;
      logic [15:0]        ac6;
      logic signed [15:0] b1;
      logic signed [15:0] b2;
      logic signed [15:0] mc;
      logic signed [15:0] md;
      logic [1:0]         oss;
   } cal_type;

   // sideband that rides along a divider
   typedef struct packed {
      logic               fault;
      logic               neg;
      logic signed [31:0] x;
      logic signed [15:0] t;
      logic [23:0]        rp;
   } side_type;

   // signed divide by 2^k, truncating toward zero
   function automatic logic signed [31:0] tdiv(input logic signed [31:0] x, input int k);
      logic signed [31:0] bias;
      bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      return (x + bias) >>> k;
   endfunction

   function automatic logic signed [31:0] sx16(input logic signed [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

endpackage

[rtl/core/bcp_udiv.sv]
// Pipelined 32/32 unsigned restoring divider, one quotient bit per stage.
// Uses bcp_pkg for the sideband type.
module bcp_udiv import bcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_num,
   input  logic [31:0] in_den,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [31:0] out_quo,
   output side_type    out_side
);

   logic        v_ff    [0:32];
   logic [31:0] rem_ff  [0:32];
   logic [31:0] num_ff  [0:32];
   logic [31:0] den_ff  [0:32];
   logic [31:0] quo_ff  [0:32];
   side_type    side_ff [0:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      rem_ff[0]  <= '0;
      num_ff[0]  <= in_num;
      den_ff[0]  <= in_den;
      quo_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   for (genvar i = 0; i < 32; i++) begin : g_stage
      logic [32:0] trial_in;
      logic [32:0] diff_in;
      logic        ge_in;
      assign trial_in = {rem_ff[i], num_ff[i][31]};
      assign diff_in  = trial_in - {1'b0, den_ff[i]};
      assign ge_in    = ~diff_in[32];
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else begin
            v_ff[i+1] <= v_ff[i];
         end
         rem_ff[i+1]  <= ge_in ? diff_in[31:0] : trial_in[31:0];
         num_ff[i+1]  <= {num_ff[i][30:0], 1'b0};
         den_ff[i+1]  <= den_ff[i];
         quo_ff[i+1]  <= {quo_ff[i][30:0], ge_in};
         side_ff[i+1] <= side_ff[i];
      end
   end

   assign out_valid = v_ff[32];
   assign out_quo   = quo_ff[32];
   assign out_side  = side_ff[32];

endmodule

[rtl/core/bcp_front.sv]
// Raw temperature front end: X1 and the temperature divisor, feeding divider one.
// Uses bcp_pkg.
module bcp_front import bcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  req_type     in_word,
   input  cal_type     cal,
   output logic        div_valid,
   output logic [31:0] div_num,
   output logic [31:0] div_den,
   output side_type    div_side
);

   logic               v1_ff, v2_ff, v3_ff;
   logic signed [31:0] a1_ff;
   logic [23:0]        rp1_ff, rp2_ff;
   logic signed [31:0] m2_ff;
   logic [31:0]        num3_ff, den3_ff;
   side_type           side3_ff;

   logic signed [31:0] x1_in, den_in, numv_in;

   assign x1_in   = m2_ff >>> 15;
   assign den_in  = x1_in + sx16(cal.md);
   assign numv_in = {{5{cal.mc[15]}}, cal.mc, 11'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      a1_ff  <= {16'b0, in_word.raw_temperature} - {16'b0, cal.ac6};
      rp1_ff <= in_word.raw_pressure;
      m2_ff  <= a1_ff * $signed({16'b0, cal.ac5});
      rp2_ff <= rp1_ff;
      num3_ff <= numv_in[31] ? 32'(-numv_in) : numv_in;
      den3_ff <= den_in[31] ? 32'(-den_in) : den_in;
      side3_ff.fault <= (den_in == 32'sd0);
      side3_ff.neg   <= numv_in[31] ^ den_in[31];
      side3_ff.x     <= x1_in;
      side3_ff.t     <= '0;
      side3_ff.rp    <= rp2_ff;
   end

   assign div_valid = v3_ff;
   assign div_num   = num3_ff;
   assign div_den   = den3_ff;
   assign div_side  = side3_ff;

endmodule

[rtl/core/bcp_mid.sv]
// Middle section: B5, temperature, B3, B4, B7, feeding divider two.
// Uses bcp_pkg.
module bcp_mid import bcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_quo,
   input  side_type    in_side,
   input  cal_type     cal,
   output logic        div_valid,
   output logic [31:0] div_num,
   output logic [31:0] div_den,
   output side_type    div_side
);

   logic [8:1] v_ff;
   logic [8:1] f_ff;
   logic signed [15:0] t_ff  [1:8];
   logic [23:0]        rp_ff [1:6];

   logic signed [31:0] b6a_ff, sqb_ff, p2b_ff, p3b_ff;
   logic signed [31:0] b6sqc_ff, x2ac_ff, x1cc_ff;
   logic signed [31:0] pb2d_ff, pb1d_ff, x2ad_ff, x1cd_ff;
   logic signed [31:0] b3pe_ff, x3se_ff;
   logic signed [31:0] b3f_ff, sf_ff;
   logic [31:0]        b4g_ff, diffg_ff;
   logic [31:0]        b7h_ff, b4h_ff;

   logic signed [31:0] x2_in, b5_in, tw_in, b3s_in, sh_in;
   logic signed [15:0] tsat_in;
   logic [31:0]        up_in, pg_in;

   assign x2_in   = in_side.neg ? 32'(-$signed(in_quo)) : $signed(in_quo);
   assign b5_in   = in_side.x + x2_in;
   assign tw_in   = (b5_in + 32'sd8) >>> 4;
   assign tsat_in = (tw_in > 32'sd32767) ? 16'sh7fff :
                    (tw_in < -32'sd32768) ? 16'sh8000 : tw_in[15:0];
   assign sh_in   = b3pe_ff <<< cal.oss;
   assign b3s_in  = tdiv(sh_in + 32'sd2, 2);
   assign up_in   = {8'b0, rp_ff[6]} >> (4'd8 - {2'b0, cal.oss});
   assign pg_in   = {16'b0, cal.ac4} * sf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[7:1], in_valid};
      end
      f_ff[7:1] <= {f_ff[6:1], in_side.fault};
      t_ff[1] <= tsat_in;
      for (int i = 2; i <= 8; i++) t_ff[i] <= t_ff[i-1];
      rp_ff[1] <= in_side.rp;
      for (int i = 2; i <= 6; i++) rp_ff[i] <= rp_ff[i-1];
      // A
      b6a_ff <= b5_in - 32'sd4000;
      // B
      sqb_ff <= b6a_ff * b6a_ff;
      p2b_ff <= sx16(cal.ac2) * b6a_ff;
      p3b_ff <= sx16(cal.ac3) * b6a_ff;
      // C
      b6sqc_ff <= tdiv(sqb_ff, 12);
      x2ac_ff  <= tdiv(p2b_ff, 11);
      x1cc_ff  <= tdiv(p3b_ff, 13);
      // D
      pb2d_ff <= sx16(cal.b2) * b6sqc_ff;
      pb1d_ff <= sx16(cal.b1) * b6sqc_ff;
      x2ad_ff <= x2ac_ff;
      x1cd_ff <= x1cc_ff;
      // E
      b3pe_ff <= (sx16(cal.ac1) <<< 2) + tdiv(pb2d_ff, 11) + x2ad_ff;
      x3se_ff <= x1cd_ff + tdiv(pb1d_ff, 16) + 32'sd2;
      // F
      b3f_ff <= b3s_in;
      sf_ff  <= tdiv(x3se_ff, 2) + 32'sd32768;
      // G
      b4g_ff   <= pg_in >> 15;
      diffg_ff <= up_in - b3f_ff;
      // H
      b7h_ff   <= diffg_ff * (32'd50000 >> cal.oss);
      b4h_ff   <= b4g_ff;
      f_ff[8]  <= f_ff[7] | (b4g_ff == 32'd0);
   end

   assign div_valid     = v_ff[8];
   assign div_num       = b7h_ff[31] ? b7h_ff : {b7h_ff[30:0], 1'b0};
   assign div_den       = b4h_ff;
   assign div_side.fault = f_ff[8];
   assign div_side.neg   = b7h_ff[31];
   assign div_side.x     = '0;
   assign div_side.t     = t_ff[8];
   assign div_side.rp    = '0;

endmodule

[rtl/core/bcp_back.sv]
// Back end: pressure correction polynomial, clamps and the result register.
// Uses bcp_pkg.
module bcp_back import bcp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] in_quo,
   input  side_type    in_side,
   output logic        out_strobe,
   output rsp_type     out_word
);

   logic [3:1]         v_ff;
   logic [3:1]         f_ff;
   logic signed [15:0] t_ff [1:3];
   logic signed [31:0] p_ff [1:3];
   logic signed [31:0] sqj_ff, m7j_ff, m3k_ff, x2k_ff, suml_ff;
   logic               strobe_ff;
   rsp_type            word_ff;

   logic signed [31:0] p_in, q8_in, pf_in;

   assign p_in  = in_side.neg ? $signed({in_quo[30:0], 1'b0}) : $signed(in_quo);
   assign q8_in = tdiv(p_in, 8);
   assign pf_in = p_ff[3] + tdiv(suml_ff, 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff      <= '0;
         strobe_ff <= 1'b0;
      end else begin
         v_ff      <= {v_ff[2:1], in_valid};
         strobe_ff <= v_ff[3];
      end
      f_ff    <= {f_ff[2:1], in_side.fault};
      t_ff[1] <= in_side.t;
      t_ff[2] <= t_ff[1];
      t_ff[3] <= t_ff[2];
      p_ff[1] <= p_in;
      p_ff[2] <= p_ff[1];
      p_ff[3] <= p_ff[2];
      sqj_ff  <= q8_in * q8_in;
      m7j_ff  <= -32'sd7357 * p_in;
      m3k_ff  <= sqj_ff * 32'sd3038;
      x2k_ff  <= tdiv(m7j_ff, 16);
      suml_ff <= tdiv(m3k_ff, 16) + x2k_ff + 32'sd3791;
      if (f_ff[3]) begin
         word_ff <= '{temperature_tenths: '0, pressure_pa: '0, divide_fault: 1'b1};
      end else begin
         word_ff.temperature_tenths <= t_ff[3];
         word_ff.pressure_pa <= pf_in[31] ? 20'd0 :
                                (pf_in > 32'sd1048575) ? 20'hfffff : pf_in[19:0];
         word_ff.divide_fault <= 1'b0;
      end
   end

   assign out_strobe = strobe_ff;
   assign out_word   = word_ff;

endmodule

[rtl/core/barometric_sensor_compensation.sv]
// Top level: calibration registers, front end, two dividers, middle and back sections.
// Uses bcp_pkg, bcp_front, bcp_udiv, bcp_mid, bcp_back.
//
// Fully pipelined: one reading is taken every clock cycle (busy is always low) and its
// result appears on rsp_data with rsp_strobe, in order. The pipeline is made of the two
// 33-stage radix-2 dividers (temperature and pressure) plus 15 stages of multiply, add
// and clamp around them.
// The receiver cannot stall; every result is shown for one cycle only. Calibration
// and oversampling writes take effect at once and should be made while idle.
module barometric_sensor_compensation import bcp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_type                  req_data,
   output logic                     rsp_strobe,
   output rsp_type                  rsp_data,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [63:0]              csr_data
);

   logic [63:0] cal_a_ff, cal_b_ff;
   logic [47:0] cal_c_ff;
   logic [1:0]  oss_ff;
   cal_type     cal;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_a_ff <= '0;
         cal_b_ff <= '0;
         cal_c_ff <= '0;
         oss_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrCalA: cal_a_ff <= csr_data;
            CsrCalB: cal_b_ff <= csr_data;
            CsrCalC: cal_c_ff <= csr_data[47:0];
            CsrOss:  oss_ff   <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   assign cal.ac1 = cal_a_ff[63:48];
   assign cal.ac2 = cal_a_ff[47:32];
   assign cal.ac3 = cal_a_ff[31:16];
   assign cal.ac4 = cal_a_ff[15:0];
   assign cal.ac5 = cal_b_ff[63:48];
   assign cal.ac6 = cal_b_ff[47:32];
   assign cal.b1  = cal_b_ff[31:16];
   assign cal.b2  = cal_b_ff[15:0];
   assign cal.mc  = cal_c_ff[31:16];
   assign cal.md  = cal_c_ff[15:0];
   assign cal.oss = oss_ff;

   assign busy = 1'b0;

   logic        d1i_valid, d1o_valid, d2i_valid, d2o_valid;
   logic [31:0] d1i_num, d1i_den, d1o_quo, d2i_num, d2i_den, d2o_quo;
   side_type    d1i_side, d1o_side, d2i_side, d2o_side;

   bcp_front u_front (
      .clock, .reset,
      .in_valid (start & ~busy),
      .in_word  (req_data),
      .cal,
      .div_valid (d1i_valid), .div_num (d1i_num), .div_den (d1i_den), .div_side (d1i_side)
   );

   bcp_udiv u_div_t (
      .clock, .reset,
      .in_valid (d1i_valid), .in_num (d1i_num), .in_den (d1i_den), .in_side (d1i_side),
      .out_valid (d1o_valid), .out_quo (d1o_quo), .out_side (d1o_side)
   );

   bcp_mid u_mid (
      .clock, .reset,
      .in_valid (d1o_valid), .in_quo (d1o_quo), .in_side (d1o_side),
      .cal,
      .div_valid (d2i_valid), .div_num (d2i_num), .div_den (d2i_den), .div_side (d2i_side)
   );

   bcp_udiv u_div_p (
      .clock, .reset,
      .in_valid (d2i_valid), .in_num (d2i_num), .in_den (d2i_den), .in_side (d2i_side),
      .out_valid (d2o_valid), .out_quo (d2o_quo), .out_side (d2o_side)
   );

   bcp_back u_back (
      .clock, .reset,
      .in_valid (d2o_valid), .in_quo (d2o_quo), .in_side (d2o_side),
      .out_strobe (rsp_strobe), .out_word (rsp_data)
   );

endmodule

[test/testbench.sv]
// Testbench for barometric_sensor_compensation: directed table plus random readings,
// every result checked in order against a built-in integer compensation predictor.
// Depends on bcp_pkg and the barometric_sensor_compensation RTL.
`timescale 1ns / 1ps

module testbench;
   import bcp_pkg::*;

   localparam int LatencyCycles = 82;
   localparam int WatchdogLimit = 4000;
   localparam int RandomWords   = 550;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   req_type                  req_data;
   logic                     rsp_strobe;
   rsp_type                  rsp_data;
   logic                     csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [63:0]              csr_data;

   barometric_sensor_compensation dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   logic [63:0] cal_a, cal_b, cal_c;
   logic [1:0]  oss_setting;

   rsp_type pending_results[$];
   int      error_count;
   int      words_sent;
   int      results_seen;
   int      fault_results;
   int      idle_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic signed [31:0] floor_shift(input logic signed [31:0] x,
                                                      input int k);
      return x >>> k;
   endfunction

   function automatic logic signed [31:0] trunc_shift(input logic signed [31:0] x,
                                                      input int k);
      longint v;
      v = x;
      return 32'(v / (64'sd1 <<< k));
   endfunction

   function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p[31:0];
   endfunction

   function automatic rsp_type compensate(input req_type r);
      rsp_type            res;
      logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic signed [31:0] ut, up, x1, x2, x3, b3, b5, b6, b6sq, t, p, den;
      logic [31:0]        b4, b7, pu;
      int                 oss;
      longint             q;
      ac1 = 32'(signed'(cal_a[63:48]));
      ac2 = 32'(signed'(cal_a[47:32]));
      ac3 = 32'(signed'(cal_a[31:16]));
      ac4 = {16'd0, cal_a[15:0]};
      ac5 = {16'd0, cal_b[63:48]};
      ac6 = {16'd0, cal_b[47:32]};
      b1  = 32'(signed'(cal_b[31:16]));
      b2  = 32'(signed'(cal_b[15:0]));
      mc  = 32'(signed'(cal_c[31:16]));
      md  = 32'(signed'(cal_c[15:0]));
      oss = oss_setting;
      ut  = {16'd0, r.raw_temperature};
      up  = {8'd0, r.raw_pressure} >> (8 - oss);
      res = '0;
      x1  = floor_shift(mul32(ut - ac6, ac5), 15);
      den = x1 + md;
      if (den == 0) begin
         res.divide_fault = 1'b1;
         return res;
      end
      q   = longint'(mul32(mc, 2048)) / longint'(den);
      x2  = q[31:0];
      b5  = x1 + x2;
      t   = floor_shift(b5 + 8, 4);
      b6   = b5 - 4000;
      b6sq = trunc_shift(mul32(b6, b6), 12);
      x1   = trunc_shift(mul32(b2, b6sq), 11);
      x2   = trunc_shift(mul32(ac2, b6), 11);
      x3   = x1 + x2;
      b3   = mul32(ac1, 4) + x3;
      b3   = b3 << oss;
      b3   = trunc_shift(b3 + 2, 2);
      x1   = trunc_shift(mul32(ac3, b6), 13);
      x2   = trunc_shift(mul32(b1, b6sq), 16);
      x3   = trunc_shift(x1 + x2 + 2, 2);
      b4   = (ac4 * (x3 + 32768)) >> 15;
      if (b4 == 0) begin
         res.divide_fault = 1'b1;
         return res;
      end
      b7 = (up - b3) * (32'd50000 >> oss);
      if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
      else pu = (b7 / b4) * 2;
      p  = pu;
      x1 = mul32(trunc_shift(p, 8), trunc_shift(p, 8));
      x1 = trunc_shift(mul32(x1, 3038), 16);
      x2 = trunc_shift(mul32(-7357, p), 16);
      p  = p + trunc_shift(x1 + x2 + 3791, 4);
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      if (p < 0) p = 0;
      if (p > 1048575) p = 1048575;
      res.temperature_tenths = t[15:0];
      res.pressure_pa        = p[19:0];
      return res;
   endfunction

   task automatic write_csr(input logic [CsrIndexWidth-1:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CsrCalA: cal_a = val;
         CsrCalB: cal_b = val;
         CsrCalC: cal_c = val & 64'hFFFF_FFFF_FFFF;
         CsrOss:  oss_setting = val[1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_word(input req_type r, input bit have_known, input rsp_type known);
      rsp_type predicted;
      predicted = compensate(r);
      if (have_known && predicted !== known) begin
         $error("predictor disagrees with table row: %h vs %h", predicted, known);
         error_count++;
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(have_known ? known : predicted);
      words_sent++;
   endtask

   task automatic idle_gap();
      int n;
      if ($urandom_range(0, 3) != 0) return;
      start <= 1'b0;
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LatencyCycles + 8) @(posedge clock);
   endtask

   // typical factory calibration
   localparam logic [63:0] TypA = {16'sd408, -16'sd72, -16'sd14383, 16'd32741};
   localparam logic [63:0] TypB = {16'd32757, 16'd23153, 16'sd6190, 16'sd4};
   localparam logic [63:0] TypC = {-16'sd32768, -16'sd8711, 16'sd2868};

   typedef struct packed {
      logic [15:0] ut;
      logic [23:0] up;
      bit          known;
      rsp_type     res;
   } table_row_type;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (rsp_data.divide_fault) fault_results++;
         if (pending_results.size() == 0) begin
            $error("result with nothing pending: %h", rsp_data);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.temperature_tenths !== want.temperature_tenths) begin
               $error("temperature_tenths expected %0d actual %0d",
                      want.temperature_tenths, rsp_data.temperature_tenths);
               error_count++;
            end
            if (rsp_data.pressure_pa !== want.pressure_pa) begin
               $error("pressure_pa expected %0d actual %0d",
                      want.pressure_pa, rsp_data.pressure_pa);
               error_count++;
            end
            if (rsp_data.divide_fault !== want.divide_fault) begin
               $error("divide_fault expected %0d actual %0d",
                      want.divide_fault, rsp_data.divide_fault);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("watchdog: no activity for %0d cycles", WatchdogLimit);
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      table_row_type rows[$];
      req_type       r;
      rsp_type       fault_res;
      int            phase;
      error_count   = 0;
      words_sent    = 0;
      results_seen  = 0;
      fault_results = 0;
      idle_cycles   = 0;
      cal_a = '0; cal_b = '0; cal_c = '0; oss_setting = '0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fault_res = '0;
      fault_res.divide_fault = 1'b1;
      // after reset all coefficients are zero: X1+MD is zero
      rows.push_back('{16'h0000, 24'h000000, 1'b1, fault_res});
      rows.push_back('{16'hFFFF, 24'hFFFFFF, 1'b1, fault_res});
      foreach (rows[i]) begin
         r.raw_temperature = rows[i].ut;
         r.raw_pressure    = rows[i].up;
         send_word(r, rows[i].known, rows[i].res);
      end
      drain();

      // typical calibration, every oversampling setting, field extremes
      write_csr(CsrCalA, TypA);
      write_csr(CsrCalB, TypB);
      write_csr(CsrCalC, TypC);
      for (int o = 0; o < 4; o++) begin
         write_csr(CsrOss, 64'(o) | 64'hFFFF_FFFF_FFFF_FFFC);
         rows.delete();
         rows.push_back('{16'd27898, 24'd23843 << 8, 1'b0, '0});
         rows.push_back('{16'h0000, 24'h000000, 1'b0, '0});
         rows.push_back('{16'hFFFF, 24'hFFFFFF, 1'b0, '0});
         rows.push_back('{16'h8000, 24'h800000, 1'b0, '0});
         rows.push_back('{16'd23153, 24'h5A5A5A, 1'b0, '0});
         foreach (rows[i]) begin
            r.raw_temperature = rows[i].ut;
            r.raw_pressure    = rows[i].up;
            send_word(r, rows[i].known, rows[i].res);
         end
         drain();
      end
      // zero pressure divisor: AC4 = 0
      write_csr(CsrCalA, {TypA[63:16], 16'd0});
      r.raw_temperature = 16'd27898;
      r.raw_pressure    = 24'h123456;
      send_word(r, 1'b1, fault_res);
      drain();
      // zero temperature divisor: AC5 = 0 makes X1 zero and MD is zero
      write_csr(CsrCalA, TypA);
      write_csr(CsrCalB, {16'd0, TypB[47:0]});
      write_csr(CsrCalC, 64'hFFFF_0000_0000_0000);
      send_word(r, 1'b1, fault_res);
      drain();

      for (phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CsrCalA, TypA); write_csr(CsrCalB, TypB);
               write_csr(CsrCalC, TypC); write_csr(CsrOss, 64'd0);
            end
            1: write_csr(CsrOss, 64'd3);
            2: begin
               write_csr(CsrCalA, {$urandom, $urandom});
               write_csr(CsrCalB, {$urandom, $urandom});
               write_csr(CsrCalC, {$urandom, $urandom});
               write_csr(CsrOss, 64'($urandom_range(0, 3)));
            end
            3: begin
               write_csr(CsrCalA, '1); write_csr(CsrCalB, '1);
               write_csr(CsrCalC, '1); write_csr(CsrOss, 64'd2);
            end
            4: begin
               write_csr(CsrCalA, {16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF});
               write_csr(CsrCalB, {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF});
               write_csr(CsrCalC, {16'h8000, 16'h7FFF, 16'h8000});
               write_csr(CsrOss, 64'd1);
            end
            default: begin
               write_csr(CsrCalA, TypA ^ 64'($urandom_range(0, 255)));
               write_csr(CsrCalB, TypB);
               write_csr(CsrCalC, TypC);
               write_csr(CsrOss, 64'($urandom_range(0, 3)));
            end
         endcase
         repeat (RandomWords / 6) begin
            if ($urandom_range(0, 9) < 7) begin
               r.raw_temperature = 16'($urandom_range(20000, 36000));
               r.raw_pressure    = 24'($urandom_range(20000, 30000)) << 8
                                   | 24'($urandom_range(0, 255));
            end else begin
               r.raw_temperature = 16'($urandom);
               r.raw_pressure    = 24'($urandom);
            end
            send_word(r, 1'b0, '0);
            idle_gap();
         end
         drain();
      end

      $display("sent %0d readings, checked %0d results (%0d divide faults)",
               words_sent, results_seen, fault_results);
      $display("covered reset, typical, random and extreme calibrations at all oversampling");
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/bcp_pkg.sv
rtl/core/bcp_udiv.sv
rtl/core/bcp_front.sv
rtl/core/bcp_mid.sv
rtl/core/bcp_back.sv
rtl/core/barometric_sensor_compensation.sv
test/testbench.sv
